/* rtl/core/ebps_pkg.sv */
// Shared types, constants and helpers for the exact byte pattern search.
// No dependencies; imported by every module in rtl/core.
package ebps_pkg;

  // Window / pattern geometry
  localparam int MAX_PATTERN = 32;
  localparam int LEN_W       = $clog2(MAX_PATTERN);      // holds length - 1
  localparam int PAT_BYTES   = 32;                        // bytes held by the pattern registers
  localparam int PAT_BITS    = PAT_BYTES * 8;
  localparam int WORD_W      = 64;
  localparam int ADDR_W      = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_LEN_W   = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT3   = 3'd4;

  // Event queue between front and back (depth must be a power of two)
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Entry 0 is the newest byte, entry k the byte k beats earlier
  typedef logic [MAX_PATTERN-1:0][7:0] win_t;
  typedef logic [MAX_PATTERN-2:0][7:0] hist_t;

  // One result event handed from front to back
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;    // address of the byte that completed the match
    logic [LEN_W-1:0]  len_m1;  // pattern length - 1 at that time
  } event_t;

  // Clamp a written length into 1..MAX_PATTERN, returned as length - 1
  function automatic logic [LEN_W-1:0] clamp_len_m1(logic [CFG_LEN_W-1:0] raw);
    logic [LEN_W-1:0] res;
    if (raw == '0) begin
      res = '0;
    end else if (int'(raw) > MAX_PATTERN) begin
      res = LEN_W'(MAX_PATTERN - 1);
    end else begin
      res = LEN_W'(int'(raw) - 1);
    end
    return res;
  endfunction

  // Pattern reversed so that entry k lines up with window entry k
  function automatic win_t align_pattern(logic [LEN_W-1:0] len_m1,
                                         logic [PAT_BITS-1:0] pat);
    win_t a;
    int   idx;
    a = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      idx = int'(len_m1) - k;
      if (idx >= 0 && idx < PAT_BYTES) begin
        a[k] = pat[idx*8 +: 8];
      end
    end
    return a;
  endfunction

endpackage

/* rtl/core/ebps_front.sv */
// Front end: configuration registers, byte window and parallel compare.
// Classifies each accepted beat and emits found / not-found events.
// Depends on ebps_pkg.
module ebps_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ebps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ebps_pkg::WORD_W-1:0]   cfg_wdata,
  input  logic                          accept,
  input  logic [7:0]                    data_byte,
  input  logic                          range_start,
  input  logic                          range_end,
  input  logic [ebps_pkg::ADDR_W-1:0]   base_address,
  output logic                          ev_valid,
  output ebps_pkg::event_t              ev
);
  import ebps_pkg::*;

  logic [LEN_W-1:0]    len_m1_r, len_m1_nxt;
  logic [PAT_BITS-1:0] pat_r, pat_nxt;
  win_t                align_r;
  hist_t               hist_r, hist_nxt;
  logic [LEN_W-1:0]    seen_r, seen_nxt;
  logic                done_r, done_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;

  logic [LEN_W-1:0]    seen_e;
  logic                done_e;
  logic [ADDR_W-1:0]   addr_e;
  win_t                win;
  logic                hit;
  logic                match;

  // Config write path; the aligned pattern follows the registers directly
  always_comb begin
    len_m1_nxt = len_m1_r;
    pat_nxt    = pat_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_LENGTH: len_m1_nxt = clamp_len_m1(cfg_wdata[CFG_LEN_W-1:0]);
        REG_PAT0:   pat_nxt[0*WORD_W +: WORD_W] = cfg_wdata;
        REG_PAT1:   pat_nxt[1*WORD_W +: WORD_W] = cfg_wdata;
        REG_PAT2:   pat_nxt[2*WORD_W +: WORD_W] = cfg_wdata;
        REG_PAT3:   pat_nxt[3*WORD_W +: WORD_W] = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_m1_r <= '0;
      pat_r    <= '0;
      align_r  <= '0;
    end else begin
      len_m1_r <= len_m1_nxt;
      pat_r    <= pat_nxt;
      align_r  <= align_pattern(len_m1_nxt, pat_nxt);
    end
  end

  // Range state as seen by this beat (a start beat restarts it)
  assign seen_e = range_start ? '0 : seen_r;
  assign done_e = range_start ? 1'b0 : done_r;
  assign addr_e = range_start ? base_address : addr_r;

  // Window: current byte plus history; stale history is masked by seen count
  assign win = {hist_r, data_byte};

  always_comb begin
    hit = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (k <= int'(len_m1_r) && align_r[k] != win[k]) begin
        hit = 1'b0;
      end
    end
  end

  assign match = !done_e && (seen_e >= len_m1_r) && hit;

  // Event out: a match, or the end of a range with none
  assign ev_valid  = accept && (match || (range_end && !done_e));
  assign ev.found  = match;
  assign ev.addr   = addr_e;
  assign ev.len_m1 = len_m1_r;

  // Next range state
  always_comb begin
    hist_nxt = win[MAX_PATTERN-2:0];
    addr_nxt = addr_e + ADDR_W'(1);
    if (range_end) begin
      seen_nxt = '0;
      done_nxt = 1'b0;
    end else begin
      seen_nxt = (seen_e == LEN_W'(MAX_PATTERN - 1)) ? seen_e : seen_e + LEN_W'(1);
      done_nxt = done_e || match;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      seen_r <= '0;
      done_r <= 1'b0;
      addr_r <= '0;
    end else if (accept) begin
      hist_r <= hist_nxt;
      seen_r <= seen_nxt;
      done_r <= done_nxt;
      addr_r <= addr_nxt;
    end
  end

endmodule

/* rtl/core/ebps_queue.sv */
// Short event queue decoupling the compare front from the result back end.
// Depends on ebps_pkg.
module ebps_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ebps_pkg::event_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             valid,
  output ebps_pkg::event_t pop_data
);
  import ebps_pkg::*;

  event_t            ent_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = ent_r[rptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + QPTR_W'(1);
      if (do_pop)  rptr_r <= rptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/ebps_back.sv */
// Back end: turns events into result beats (start address of the match)
// and holds them in the output register. Depends on ebps_pkg.
module ebps_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ev_valid,
  input  ebps_pkg::event_t            ev,
  output logic                        ev_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_found,
  output logic [ebps_pkg::ADDR_W-1:0] out_match_address
);
  import ebps_pkg::*;

  logic              valid_r;
  logic              found_r;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              load;

  // Take a new event when the output register is free or being drained
  assign load   = ev_valid && (!valid_r || out_pop);
  assign ev_pop = load;

  // Match start = completing byte address - (length - 1); zero when not found
  assign addr_nxt = ev.found ? (ev.addr - ADDR_W'(ev.len_m1)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      found_r <= ev.found;
      addr_r  <= addr_nxt;
    end
  end

  assign out_empty         = !valid_r;
  assign out_found         = found_r;
  assign out_match_address = addr_r;

endmodule

/* rtl/core/exact_byte_pattern_search.sv */
// Exact byte pattern search: one range byte is taken per clock cycle while
// in_full is low, and every byte is compared against the whole pattern in
// parallel in the front end. The event for a result enters a two-entry
// event queue at the edge that accepts the byte that caused it, and moves
// into the output register once that register is empty or being popped.
// in_full rises only when that queue is full, i.e. when results back up
// behind an un-popped output. A range closed by its last byte yields
// exactly one result: the start address of its first match, or found = 0
// with address 0 at its last byte; a range cut short by a new start before
// any match yields none. Configuration writes take effect on the next
// cycle. Depends on ebps_pkg, ebps_front, ebps_queue and ebps_back.
module exact_byte_pattern_search (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ebps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ebps_pkg::WORD_W-1:0]    cfg_wdata,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_range_start,
  input  logic                           in_range_end,
  input  logic [ebps_pkg::ADDR_W-1:0]    in_base_address,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic                           out_found,
  output logic [ebps_pkg::ADDR_W-1:0]    out_match_address
);
  import ebps_pkg::*;

  logic   accept;
  logic   fr_valid;
  event_t fr_ev;
  logic   q_full;
  logic   q_valid;
  event_t q_ev;
  logic   q_pop;

  // Input beat accepted while the event queue has room
  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  ebps_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .accept       (accept),
    .data_byte    (in_data_byte),
    .range_start  (in_range_start),
    .range_end    (in_range_end),
    .base_address (in_base_address),
    .ev_valid     (fr_valid),
    .ev           (fr_ev)
  );

  ebps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fr_valid),
    .push_data (fr_ev),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .pop_data  (q_ev)
  );

  ebps_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .ev_valid          (q_valid),
    .ev                (q_ev),
    .ev_pop            (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_found         (out_found),
    .out_match_address (out_match_address)
  );

endmodule
